// ===== hdl/ksa_pkg.sv =====
// ----------------------------------------------------------------------------
// ksa_pkg
// Shared types and field widths for the key slot allocator table.
// ----------------------------------------------------------------------------
package ksa_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 8;
  localparam int VALUE_W = 32;
  localparam int AKEY_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_SET   = 2'd2,
    KIND_GET   = 2'd3
  } kind_t;

  // status of the key map for the item being accepted
  typedef struct packed {
    logic live;     // key in range and allocated
    logic written;  // table entry holds a value stored since allocation
    logic found;    // a free key exists for allocate
  } map_stat_t;

endpackage

// ===== hdl/ksa_value_mem.sv =====
// ----------------------------------------------------------------------------
// ksa_value_mem
// Value table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ksa_value_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ksa_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [ksa_pkg::VALUE_W-1:0] rdata
);
  import ksa_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while the result waits downstream
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ksa_key_map.sv =====
// ----------------------------------------------------------------------------
// ksa_key_map
// In-use bitmap, per-entry written flags and lowest-free-key encoder.
// ----------------------------------------------------------------------------
module ksa_key_map #(
  parameter int MAX_KEYS = 64,
  parameter int KW       = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  ksa_pkg::kind_t            kind,
  input  logic [ksa_pkg::KEY_W-1:0] key,
  output ksa_pkg::map_stat_t        stat,
  output logic [KW-1:0]             free_idx
);
  import ksa_pkg::*;

  logic [MAX_KEYS-1:0] map_r;
  logic [MAX_KEYS-1:0] wr_r;
  logic [KW-1:0]       key_idx;
  logic                in_range;
  logic                found;
  logic [KW-1:0]       idx;

  assign key_idx  = key[KW-1:0];
  assign in_range = (key != '0) && (key < KEY_W'(MAX_KEYS));

  // lowest free key from 1 upward
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = MAX_KEYS - 1; k >= 1; k--) begin
      if (!map_r[k]) begin
        found = 1'b1;
        idx   = KW'(k);
      end
    end
  end

  assign free_idx     = idx;
  assign stat.found   = found;
  assign stat.live    = in_range && map_r[key_idx];
  assign stat.written = wr_r[key_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
      wr_r  <= '0;
    end else if (acc) begin
      case (kind)
        KIND_ALLOC: begin
          if (found) begin
            map_r[idx] <= 1'b1;
          end
        end
        KIND_FREE: begin
          // dropping the written flag makes the entry read as zero
          if (stat.live) begin
            map_r[key_idx] <= 1'b0;
            wr_r[key_idx]  <= 1'b0;
          end
        end
        KIND_SET: begin
          if (stat.live) begin
            wr_r[key_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/key_slot_allocator_table_unit.sv =====
// ----------------------------------------------------------------------------
// key_slot_allocator_table_unit
// Bitmap key allocator with a 32-bit value table per key.
// ----------------------------------------------------------------------------
// Output: the result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while in_ready holds; the bitmap update and
//   table access finish at accept, so the next item sees them at once.
// Reset: clears the bitmap, the written flags and the output valid flag; the
//   value table itself is not cleared, unwritten entries read 0.
module key_slot_allocator_table_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ksa_pkg::KIND_W-1:0]  in_kind,
  input  logic [ksa_pkg::KEY_W-1:0]   in_key,
  input  logic [ksa_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [ksa_pkg::AKEY_W-1:0]  out_allocated_key,
  output logic [ksa_pkg::VALUE_W-1:0] out_read_value
);
  import ksa_pkg::*;

  localparam int KW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;

  kind_t              kind;
  logic               acc;
  map_stat_t          stat;
  logic [KW-1:0]      free_idx;
  logic [VALUE_W-1:0] rdata;

  logic               out_valid_r;
  logic               out_ok_r, out_ok_nxt;
  logic [AKEY_W-1:0]  akey_r, akey_nxt;
  logic               rd_sel_r, rd_sel_nxt;

  assign kind     = kind_t'(in_kind);
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  ksa_key_map #(
    .MAX_KEYS (MAX_KEYS),
    .KW       (KW)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .kind     (kind),
    .key      (in_key),
    .stat     (stat),
    .free_idx (free_idx)
  );

  ksa_value_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (KW)
  ) u_mem (
    .clk   (clk),
    .we    (acc && (kind == KIND_SET) && stat.live),
    .waddr (in_key[KW-1:0]),
    .wdata (in_value),
    .re    (acc && (kind == KIND_GET)),
    .raddr (in_key[KW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    out_ok_nxt = 1'b0;
    akey_nxt   = '0;
    rd_sel_nxt = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        out_ok_nxt = stat.found;
        if (stat.found) begin
          akey_nxt = AKEY_W'(free_idx);
        end
      end
      KIND_GET: begin
        out_ok_nxt = stat.live;
        rd_sel_nxt = stat.live && stat.written;
      end
      default: out_ok_nxt = stat.live;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_ok_r <= out_ok_nxt;
      akey_r   <= akey_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_allocated_key = akey_r;
  assign out_read_value    = rd_sel_r ? rdata : '0;

endmodule
